### design/prr_pkg.sv
// Shared types, codes and defaults for the polyphase rational resampler.
package prr_pkg;

    localparam int COEF_DEPTH_DEF  = 256;
    localparam int DELAY_DEPTH_DEF = 256;
    localparam int MAX_FACTOR_DEF  = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int PHASE_W     = 7;
    localparam int FACTOR_W    = 7;
    localparam int FLEN_W      = 9;
    localparam int CIDX_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int OP_W        = 2;
    localparam int ROUND_SHIFT = 15;
    localparam int ROUND_BIAS  = 16384;

    localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLEN   = 2'd2;

    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_LOAD,
        KIND_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CIDX_W-1:0]    addr;
        logic [SAMPLE_W-1:0]  data;
    } t_item;

    typedef struct packed {
        logic [FACTOR_W-1:0] interp;
        logic [FACTOR_W-1:0] decim;
        logic [FLEN_W-1:0]   flen;
    } t_cfg;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

### design/prr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/prr_front.sv
// Input front end: accepts transactions, classifies them, drops no-ops and out-of-range loads.
module prr_front import prr_pkg::*; #(
    parameter int COEF_DEPTH = COEF_DEPTH_DEF
) (
    input  logic                i_in_valid,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SAMPLE_W-1:0] i_in_sample,
    input  logic [CIDX_W-1:0]   i_coef_index,
    input  logic [SAMPLE_W-1:0] i_coef_value,
    output logic                o_in_stall,
    input  logic                i_q_full,
    output logic                o_push,
    output t_item               o_item
);

    logic keep;

    always_comb begin
        keep          = 1'b0;
        o_item.kind   = KIND_PUSH;
        o_item.addr   = i_coef_index;
        o_item.data   = i_in_sample;
        unique case (i_op)
            OP_PUSH: begin
                keep = 1'b1;
            end
            OP_LOAD: begin
                keep        = (32'(i_coef_index) < COEF_DEPTH);
                o_item.kind = KIND_LOAD;
                o_item.data = i_coef_value;
            end
            OP_CLEAR: begin
                keep        = 1'b1;
                o_item.kind = KIND_CLEAR;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && keep;

endmodule

### design/prr_queue.sv
// Short command queue between the front end and the filter engine.
module prr_queue import prr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [QPW-1:0] r_wr, n_wr;
    logic [QPW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == QCW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + QCW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### design/prr_back.sv
// Filter engine: tap sequencer, shared multiply-accumulate and output register.
module prr_back import prr_pkg::*; #(
    parameter int COEF_DEPTH  = COEF_DEPTH_DEF,
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int MAX_FACTOR  = MAX_FACTOR_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    output logic [SAMPLE_W-1:0] o_out_sample,
    output logic                o_out_last,
    input  logic                i_out_stall
);

    localparam int CAW = $clog2(COEF_DEPTH);
    localparam int DAW = $clog2(DELAY_DEPTH);
    localparam int FW  = $clog2(DELAY_DEPTH + 1);
    localparam int FLW = $clog2(COEF_DEPTH + 1);
    localparam int IW  = $clog2(COEF_DEPTH + 2 * MAX_FACTOR);
    localparam int ACW = PROD_W + DAW;
    localparam int RW  = ACW + 1;
    localparam int QW  = RW - ROUND_SHIFT;

    typedef struct packed {
        logic vld;
        logic ok;
        logic first;
        logic blast;
        logic olast;
    } t_slot;

    t_state              r_state, n_state;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [IW-1:0]       r_idx, n_idx;
    logic [FW-1:0]       r_j, n_j;
    logic [DAW-1:0]      r_rp, n_rp;
    logic [DAW-1:0]      r_wp, n_wp;
    logic [FW-1:0]       r_fill, n_fill;
    t_slot               slot, r_s1, r_s2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACW-1:0]    r_acc;
    logic                r_acc_done;
    logic                r_acc_last;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_last;

    logic [FACTOR_W-1:0] lval, mval;
    logic [FLW-1:0]      flen;
    logic                en;
    logic                term_ok, cont, olast, phase_ge;
    logic [IW-1:0]       idx_step;
    logic [FW-1:0]       j_step;
    logic [PHASE_W:0]    psum;
    logic [DAW-1:0]      rp_dec, wp_inc;
    logic [FW-1:0]       fill_inc;
    logic                coef_we, delay_we;
    logic [SAMPLE_W-1:0] coef_rdata, delay_rdata;
    logic signed [SAMPLE_W-1:0] coef_q, delay_q;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [RW-1:0]       rnd;
    logic signed [QW-1:0]       quo;
    logic                       ovf;
    logic [SAMPLE_W-1:0]        sat;

    // clamp configuration to its legal range
    assign lval = (i_cfg.interp == '0) ? FACTOR_W'(1) :
                  (32'(i_cfg.interp) > MAX_FACTOR) ? FACTOR_W'(MAX_FACTOR) : i_cfg.interp;
    assign mval = (i_cfg.decim == '0) ? FACTOR_W'(1) :
                  (32'(i_cfg.decim) > MAX_FACTOR) ? FACTOR_W'(MAX_FACTOR) : i_cfg.decim;
    assign flen = (i_cfg.flen == '0) ? FLW'(1) :
                  (32'(i_cfg.flen) > COEF_DEPTH) ? FLW'(COEF_DEPTH) : FLW'(i_cfg.flen);

    assign en = !r_out_valid || !i_out_stall;

    assign term_ok  = (r_idx < IW'(flen)) && (r_j < r_fill);
    assign idx_step = r_idx + IW'(lval);
    assign j_step   = r_j + FW'(1);
    assign cont     = (idx_step < IW'(flen)) && (j_step < FW'(DELAY_DEPTH));
    assign psum     = {1'b0, r_phase} + {1'b0, mval};
    assign olast    = (psum >= {1'b0, lval});
    assign phase_ge = (r_phase >= lval);
    assign rp_dec   = (r_rp == '0) ? DAW'(DELAY_DEPTH - 1) : r_rp - DAW'(1);
    assign wp_inc   = (r_wp == DAW'(DELAY_DEPTH - 1)) ? '0 : r_wp + DAW'(1);
    assign fill_inc = (r_fill == FW'(DELAY_DEPTH)) ? r_fill : r_fill + FW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (en && i_q_valid && (i_q_item.kind == KIND_PUSH) && !phase_ge) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (en && !cont && olast) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_j      = r_j;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_fill   = r_fill;
        o_q_pop  = 1'b0;
        coef_we  = 1'b0;
        delay_we = 1'b0;
        slot     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (en && i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.kind)
                        KIND_LOAD: begin
                            coef_we = 1'b1;
                        end
                        KIND_CLEAR: begin
                            n_wp    = '0;
                            n_fill  = '0;
                            n_phase = '0;
                        end
                        KIND_PUSH: begin
                            delay_we = 1'b1;
                            n_wp     = wp_inc;
                            n_fill   = fill_inc;
                            n_rp     = wp_inc;
                            n_idx    = IW'(r_phase);
                            n_j      = '0;
                            if (phase_ge) begin
                                n_phase = r_phase - lval;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (en) begin
                    slot.vld   = 1'b1;
                    slot.ok    = term_ok;
                    slot.first = (r_j == '0);
                    slot.blast = !cont;
                    slot.olast = !cont && olast;
                    if (cont) begin
                        n_idx = idx_step;
                        n_j   = j_step;
                        n_rp  = rp_dec;
                    end else if (olast) begin
                        n_phase = PHASE_W'(psum - {1'b0, lval});
                    end else begin
                        n_phase = psum[PHASE_W-1:0];
                        n_idx   = IW'(psum);
                        n_j     = '0;
                        n_rp    = r_wp;
                    end
                end
            end
        endcase
    end

    prr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (CAW'(i_q_item.addr)),
        .i_wdata (i_q_item.data),
        .i_re    (en),
        .i_raddr (CAW'(r_idx)),
        .o_rdata (coef_rdata)
    );

    prr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (delay_we),
        .i_waddr (wp_inc),
        .i_wdata (i_q_item.data),
        .i_re    (en),
        .i_raddr (r_rp),
        .o_rdata (delay_rdata)
    );

    assign coef_q    = coef_rdata;
    assign delay_q   = delay_rdata;
    assign prod_full = PROD_W'(coef_q) * PROD_W'(delay_q);

    // round half up by the Q15 shift, then saturate
    assign rnd = RW'(r_acc) + RW'(ROUND_BIAS);
    assign quo = rnd[RW-1:ROUND_SHIFT];
    assign ovf = (quo[QW-1:SAMPLE_W-1] != '0) && (quo[QW-1:SAMPLE_W-1] != '1);
    assign sat = ovf ? (quo[QW-1] ? SAT_MIN : SAT_MAX) : quo[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            if (en) begin
                r_s1        <= slot;
                r_s2        <= r_s1;
                r_acc_done  <= r_s2.vld && r_s2.blast;
                r_out_valid <= r_acc_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_j   <= n_j;
        r_rp  <= n_rp;
        if (en) begin
            r_prod     <= r_s1.ok ? prod_full : '0;
            r_acc_last <= r_s2.olast;
            if (r_s2.vld) begin
                r_acc <= r_s2.first ? ACW'(r_prod) : r_acc + ACW'(r_prod);
            end
            if (r_acc_done) begin
                r_out_sample <= sat;
                r_out_last   <= r_acc_last;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_last   = r_out_last;

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_acc) && $stable(r_s2)))
        else $error("accumulator moved while output stalled");

    a_run_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_phase < lval))
        else $error("sequencer running with phase not below L");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DELAY_DEPTH))
        else $error("fill count beyond delay depth");

    a_tap_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && (r_j != '0)) |-> (r_idx < IW'(flen)))
        else $error("tap index beyond filter length");
`endif

endmodule

### design/polyphase_rational_resampler.sv
// Top level of the L:M polyphase rational resampler.
//
// Input channel (i_in_valid / o_in_stall): op 0 pushes i_in_sample, op 1 loads
// i_coef_value at i_coef_index, op 2 clears the delay line and phase, op 3 is
// dropped. Load coefficients below filter_length before pushing samples.
// Output channel (o_out_valid / i_out_stall): one Q1.15 result per polyphase
// branch visited; o_last marks the final result of an input sample.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 L, 1 M, 2 filter length); write only while the block is idle.
// A four-entry queue sits between the input and the filter engine.
// Each push issues one multiply-accumulate per tap of each branch visited (at
// least one per branch); the engine pops another queued item only after the
// last branch is issued, and loads and clears are handled straight from idle.
// Path of a result: queue, sequencer, RAM read and slot register, product
// register, accumulator and output register.
// Reset clears the queue, phase, delay line fill count and registers to
// L = M = filter_length = 1; coefficients are kept undefined until loaded.
// While the receiver stalls a valid result, it stays held and the engine freezes.
module polyphase_rational_resampler import prr_pkg::*; #(
    parameter int COEF_DEPTH  = COEF_DEPTH_DEF,
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int MAX_FACTOR  = MAX_FACTOR_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [SAMPLE_W-1:0]   i_in_sample,
    input  logic [CIDX_W-1:0]     i_coef_index,
    input  logic [SAMPLE_W-1:0]   i_coef_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SAMPLE_W-1:0]   o_out_sample,
    output logic                  o_last
);

    t_cfg  r_cfg;
    logic  q_full, q_push, q_valid, q_pop;
    t_item f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interp <= FACTOR_W'(1);
            r_cfg.decim  <= FACTOR_W'(1);
            r_cfg.flen   <= FLEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INTERP: r_cfg.interp <= i_cfg_data[FACTOR_W-1:0];
                CFG_DECIM:  r_cfg.decim  <= i_cfg_data[FACTOR_W-1:0];
                CFG_FLEN:   r_cfg.flen   <= i_cfg_data[FLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    prr_front #(
        .COEF_DEPTH (COEF_DEPTH)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .i_op         (i_op),
        .i_in_sample  (i_in_sample),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_in_stall   (o_in_stall),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_item       (f_item)
    );

    prr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    prr_back #(
        .COEF_DEPTH  (COEF_DEPTH),
        .DELAY_DEPTH (DELAY_DEPTH),
        .MAX_FACTOR  (MAX_FACTOR)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .o_out_sample (o_out_sample),
        .o_out_last   (o_last),
        .i_out_stall  (i_out_stall)
    );

endmodule

### tb/sv/tb_polyphase_rational_resampler.sv
// Self-checking testbench for the L:M polyphase rational resampler, with an in-line predictor.
`timescale 1ns / 1ps

module tb_polyphase_rational_resampler;
    import prr_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int MAX_REPORTS   = 10;
    localparam int RAND_ITEMS    = 12;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                last;
    } t_out;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic [OP_W-1:0]       i_op         = '0;
    logic [SAMPLE_W-1:0]   i_in_sample  = '0;
    logic [CIDX_W-1:0]     i_coef_index = '0;
    logic [SAMPLE_W-1:0]   i_coef_value = '0;
    logic                  i_out_stall  = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [SAMPLE_W-1:0]   o_out_sample;
    logic                  o_last;

    polyphase_rational_resampler i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_in_sample  (i_in_sample),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_sample (o_out_sample),
        .o_last       (o_last)
    );

    // predictor state
    logic signed [SAMPLE_W-1:0] coef_mem [COEF_DEPTH_DEF];
    bit                         coef_set [COEF_DEPTH_DEF];
    logic signed [SAMPLE_W-1:0] line_mem [DELAY_DEPTH_DEF];
    logic [7:0]                 head;
    int                         phase;
    logic [FACTOR_W-1:0]        reg_interp;
    logic [FACTOR_W-1:0]        reg_decim;
    logic [FLEN_W-1:0]          reg_flen;

    t_out exp_q [$];
    int   n_fail      = 0;
    int   cycles      = 0;
    int   idle_pct    = 0;
    int   stall_pct   = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_flow();
        for (int i = 0; i < DELAY_DEPTH_DEF; i++) line_mem[i] = '0;
        head  = '0;
        phase = 0;
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < COEF_DEPTH_DEF; i++) begin
            coef_mem[i] = '0;
            coef_set[i] = 1'b0;
        end
        clear_flow();
        reg_interp = 7'd1;
        reg_decim  = 7'd1;
        reg_flen   = 9'd1;
    endfunction

    // one polyphase branch, rounded half up and saturated
    function automatic logic [SAMPLE_W-1:0] fir_branch(int ph, int L, int F);
        longint acc;
        longint q;
        int     idx;
        int     j;
        int     pos;
        acc = 0;
        idx = ph;
        j   = 0;
        while (idx < F && j < DELAY_DEPTH_DEF) begin
            pos = (head + DELAY_DEPTH_DEF - j) % DELAY_DEPTH_DEF;
            acc += longint'(coef_mem[idx]) * longint'(line_mem[pos]);
            idx += L;
            j++;
        end
        q = (acc + ROUND_BIAS) >>> ROUND_SHIFT;
        if (q > 32767) return SAT_MAX;
        if (q < -32768) return SAT_MIN;
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic void predict(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp,
            logic [CIDX_W-1:0] cidx, logic [SAMPLE_W-1:0] cval);
        int L;
        int M;
        int F;
        int nxt;
        L = clamp(int'(reg_interp), 1, MAX_FACTOR_DEF);
        M = clamp(int'(reg_decim), 1, MAX_FACTOR_DEF);
        F = clamp(int'(reg_flen), 1, COEF_DEPTH_DEF);
        case (op)
            OP_LOAD: begin
                coef_mem[cidx] = cval;
                coef_set[cidx] = 1'b1;
            end
            OP_CLEAR: clear_flow();
            OP_PUSH: begin
                head = head + 1'b1;
                line_mem[head] = smp;
                while (phase < L) begin
                    nxt = phase + M;
                    exp_q.push_back('{fir_branch(phase, L, F), nxt >= L});
                    phase = nxt;
                end
                phase = (phase - L) & 127;
            end
            default: ;
        endcase
    endfunction

    function automatic void report_mismatch(string what, logic [SAMPLE_W-1:0] want,
            logic [SAMPLE_W-1:0] got);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("mismatch %s at cycle %0d: expected %h, got %h", what, cycles, want, got);
    endfunction

    // result checker and receiver stall
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_q.size() == 0) begin
                report_mismatch("unexpected transaction", '0, o_out_sample);
            end else begin
                want = exp_q.pop_front();
                if (o_out_sample !== want.smp) report_mismatch("out_sample", want.smp, o_out_sample);
                if (o_last !== want.last)
                    report_mismatch("last", SAMPLE_W'(want.last), SAMPLE_W'(o_last));
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [SAMPLE_W-1:0] rand_word();
        case ($urandom_range(7))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2, 3:    return SAMPLE_W'(int'($urandom_range(2047)) - 1024);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp,
            logic [CIDX_W-1:0] cidx, logic [SAMPLE_W-1:0] cval);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_in_sample  <= smp;
        i_coef_index <= cidx;
        i_coef_value <= cval;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict(op, smp, cidx, cval);
    endtask

    task automatic load_coef(logic [CIDX_W-1:0] cidx, logic [SAMPLE_W-1:0] cval);
        send_item(OP_LOAD, SAMPLE_W'($urandom), cidx, cval);
    endtask

    // loads every tap that the next push reads and that is still unwritten
    task automatic load_needed_taps();
        int L;
        int M;
        int F;
        int p;
        int idx;
        int j;
        L = clamp(int'(reg_interp), 1, MAX_FACTOR_DEF);
        M = clamp(int'(reg_decim), 1, MAX_FACTOR_DEF);
        F = clamp(int'(reg_flen), 1, COEF_DEPTH_DEF);
        p = phase;
        while (p < L) begin
            idx = p;
            j   = 0;
            while (idx < F && j < DELAY_DEPTH_DEF) begin
                if (!coef_set[idx]) load_coef(CIDX_W'(idx), rand_word());
                idx += L;
                j++;
            end
            p += M;
        end
    endtask

    task automatic push_sample(logic [SAMPLE_W-1:0] smp);
        load_needed_taps();
        send_item(OP_PUSH, smp, CIDX_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes all three registers once the block is idle
    task automatic set_config(logic [CFG_DATA_W-1:0] l, logic [CFG_DATA_W-1:0] m,
            logic [CFG_DATA_W-1:0] f);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_INTERP;
        i_cfg_data  <= l;
        @(posedge i_clk);
        reg_interp  = l[FACTOR_W-1:0];
        i_cfg_index <= CFG_DECIM;
        i_cfg_data  <= m;
        @(posedge i_clk);
        reg_decim   = m[FACTOR_W-1:0];
        i_cfg_index <= CFG_FLEN;
        i_cfg_data  <= f;
        @(posedge i_clk);
        reg_flen    = f;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_factor();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'(MAX_FACTOR_DEF);
            2:       return CFG_DATA_W'($urandom_range(65, 511));
            default: return CFG_DATA_W'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic random_config();
        logic [CFG_DATA_W-1:0] f;
        case ($urandom_range(11))
            0:       f = '0;
            1:       f = CFG_DATA_W'($urandom_range(41, 72));
            default: f = CFG_DATA_W'($urandom_range(1, 40));
        endcase
        set_config(pick_factor(), pick_factor(), f);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            push_sample(rand_word());
        else if (r < 90)
            load_coef(CIDX_W'($urandom), rand_word());
        else if (r < 95)
            send_item(OP_CLEAR, SAMPLE_W'($urandom), CIDX_W'($urandom), SAMPLE_W'($urandom));
        else
            send_item(OP_NONE, SAMPLE_W'($urandom), CIDX_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic test_reset_state();
        load_coef(8'd0, 16'h2000);
        push_sample(16'h4000);
        push_sample(16'hC000);
        push_sample(16'h7FFF);
    endtask

    task automatic test_saturation_rounding();
        set_config(9'd1, 9'd1, 9'd4);
        for (int i = 0; i < 4; i++) load_coef(CIDX_W'(i), SAT_MIN);
        repeat (4) push_sample(SAT_MAX);
        repeat (4) push_sample(SAT_MIN);
        load_coef(8'd0, 16'h4000);
        for (int i = 1; i < 4; i++) load_coef(CIDX_W'(i), '0);
        push_sample(16'h0001);   // half LSB up
        push_sample(16'hFFFF);   // minus half rounds to zero
        push_sample(16'h0003);
    endtask

    task automatic test_factor_extremes();
        set_config(9'd64, 9'd1, 9'd16);
        repeat (2) push_sample(rand_word());
        set_config(9'd1, 9'd64, 9'd8);
        repeat (3) push_sample(rand_word());
        set_config(9'd5, 9'd3, 9'd20);
        repeat (4) push_sample(rand_word());
    endtask

    task automatic test_out_of_range();
        set_config(9'd0, 9'd0, 9'd0);
        repeat (2) push_sample(rand_word());
        set_config(9'h1FF, 9'h1FF, 9'h1FF);
        repeat (2) push_sample(rand_word());
        set_config(9'd40, 9'd70, 9'd300);
        repeat (2) push_sample(rand_word());
    endtask

    // shrinking L leaves the phase at or above it; those pushes give nothing
    task automatic test_phase_carry();
        set_config(9'd10, 9'd9, 9'd30);
        repeat (5) push_sample(rand_word());
        set_config(9'd2, 9'd1, 9'd30);
        repeat (5) push_sample(rand_word());
    endtask

    task automatic test_clear_and_unused();
        set_config(9'd3, 9'd2, 9'd12);
        repeat (3) push_sample(rand_word());
        send_item(OP_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_item(OP_NONE, 16'hFFFF, 8'hFF, 16'hFFFF);
        repeat (3) push_sample(rand_word());
        send_item(OP_CLEAR, '0, '0, '0);
        repeat (2) push_sample(rand_word());
    endtask

    task automatic test_drain_pause();
        idle_pct  = 20;
        stall_pct = 20;
        random_config();
        repeat (6) push_sample(rand_word());
        wait_drained();
        repeat (6) push_sample(rand_word());
    endtask

    task automatic test_random(int send_idle, int recv_stall);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        repeat (2) begin
            random_config();
            for (int k = 0; k < RAND_ITEMS / 2; k++)
                random_item();
        end
    endtask

    initial begin
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_saturation_rounding();
        test_factor_extremes();
        test_out_of_range();
        test_phase_carry();
        test_clear_and_unused();
        test_drain_pause();
        test_random(0, 0);
        test_random(62, 0);
        test_random(0, 62);
        test_random(20, 20);
        wait_drained();
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
design/prr_pkg.sv
design/prr_ram.sv
design/prr_front.sv
design/prr_queue.sv
design/prr_back.sv
design/polyphase_rational_resampler.sv
tb/sv/tb_polyphase_rational_resampler.sv
